@@ design/hcm_pkg.sv @@
// Shared constants, command/status structs and slot-layout helpers for the
// harmonic conjugate momentum block. No dependencies.
package hcm_pkg;

  localparam int MAX_DIM_DEF    = 3;
  localparam int VALUE_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF  = 24;
  localparam int FIELD_BITS     = 48;
  localparam int SLOT_BITS      = 6;
  localparam int IDX_BITS       = 4;
  localparam int DIM_BITS       = 2;

  localparam logic [SLOT_BITS-1:0] SLOT_LAPSE    = SLOT_BITS'(0);
  localparam logic [SLOT_BITS-1:0] SLOT_DT_LAPSE = SLOT_BITS'(1);

  // Controller to datapath
  typedef struct packed {
    logic                 wr_en;
    logic [SLOT_BITS-1:0] rd_slot;
    logic                 ld_n;
    logic                 ld_opa;
    logic                 mul_start;
    logic                 mul_sel_prod;
    logic                 acc_clr;
    logic                 comb;
    logic                 comb_load;
    logic                 comb_dbl;
    logic                 comb_sub;
    logic                 div_start;
    logic                 out_load;
    logic                 res_zero;
    logic [IDX_BITS-1:0]  out_idx;
    logic                 out_last;
  } hcm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_zero;
    logic mul_busy;
    logic mul_done;
    logic div_done;
  } hcm_sts_t;

  // Row-major upper-triangle index of (a,b) in an n by n symmetric tensor
  function automatic int sym_idx(input int a, input int b, input int n);
    int lo;
    int hi;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    return ((lo * (2 * n - lo - 1)) >> 1) + hi;
  endfunction

  function automatic int nsym(input int md);
    return (md * (md + 1)) >> 1;
  endfunction

  function automatic int ncomp(input int md);
    return ((md + 1) * (md + 2)) >> 1;
  endfunction

  function automatic int nslots(input int md);
    return 2 + 2 * md + 2 * nsym(md) + md * ncomp(md);
  endfunction

  function automatic logic [SLOT_BITS-1:0] slot_shift(input int i, input int md);
    return SLOT_BITS'(2 + i);
  endfunction

  function automatic logic [SLOT_BITS-1:0] slot_dtshift(input int i, input int md);
    return SLOT_BITS'(2 + md + i);
  endfunction

  function automatic logic [SLOT_BITS-1:0] slot_g(input int i, input int j, input int md);
    return SLOT_BITS'(2 + 2 * md + sym_idx(i, j, md));
  endfunction

  function automatic logic [SLOT_BITS-1:0] slot_dtg(input int i, input int j, input int md);
    return SLOT_BITS'(2 + 2 * md + nsym(md) + sym_idx(i, j, md));
  endfunction

  function automatic logic [SLOT_BITS-1:0] slot_phi(input int i, input int c, input int md);
    return SLOT_BITS'(2 + 2 * md + 2 * nsym(md) + i * ncomp(md) + c);
  endfunction

  function automatic logic [IDX_BITS-1:0] comp_idx(input int a, input int b, input int md);
    return IDX_BITS'(sym_idx(a, b, md + 1));
  endfunction

endpackage

@@ design/hcm_if.sv @@
// Valid/ready channel interfaces for operand words and result words.
// Depends on hcm_pkg for field widths.
interface hcm_in_if;
  logic                                valid;
  logic                                ready;
  logic [hcm_pkg::SLOT_BITS-1:0]       operand_slot;
  logic signed [hcm_pkg::FIELD_BITS-1:0] operand_value;
  logic                                last_operand;
  modport source(output valid, operand_slot, operand_value, last_operand, input ready);
  modport sink(input valid, operand_slot, operand_value, last_operand, output ready);
endinterface

interface hcm_out_if;
  logic                                valid;
  logic                                ready;
  logic [hcm_pkg::IDX_BITS-1:0]        component_index;
  logic signed [hcm_pkg::FIELD_BITS-1:0] component_value;
  logic                                error_flag;
  logic                                last_component;
  modport source(output valid, component_index, component_value, error_flag,
                 last_component, input ready);
  modport sink(input valid, component_index, component_value, error_flag,
               last_component, output ready);
endinterface

@@ design/hcm_mul.sv @@
// Sequential shift-add multiplier with rounding to the fraction point and
// saturation. Depends on hcm_pkg for parameter defaults.
module hcm_mul #(
  parameter int VB = hcm_pkg::VALUE_BITS_DEF,
  parameter int FB = hcm_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [VB-1:0] a,
  input  logic signed [VB-1:0] b,
  output logic                 busy,
  output logic                 done,
  output logic signed [VB-1:0] p,
  output logic                 err
);

  localparam int PW = 2 * VB + 1;
  localparam int CW = $clog2(VB + 1);
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FB - 1);
  localparam logic signed [PW-1:0] P_HI = (PW'(1) <<< (VB - 1)) - PW'(1);
  localparam logic signed [PW-1:0] P_LO = -P_HI - PW'(1);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t              st_r;
  logic [CW-1:0]        cnt_r;
  logic [VB-1:0]        hi_r;
  logic [VB-1:0]        lo_r;
  logic [VB-1:0]        mc_r;
  logic                 neg_r;
  logic                 done_r;
  logic signed [VB-1:0] p_r;
  logic                 err_r;

  logic [VB-1:0]        mag_a;
  logic [VB-1:0]        mag_b;
  logic [VB:0]          psum;
  logic signed [PW-1:0] full;
  logic signed [PW-1:0] rnd;

  assign mag_a = a[VB-1] ? (~a + 1'b1) : a;
  assign mag_b = b[VB-1] ? (~b + 1'b1) : b;
  assign psum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mc_r} : {(VB+1){1'b0}});

  // Signed product, rounded half up, then arithmetic shift
  always_comb begin
    full = {1'b0, hi_r, lo_r};
    if (neg_r) begin
      full = -full;
    end
    rnd = (full + HALF) >>> FB;
  end

  // Step the multiplier one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == M_FIN);
      unique case (st_r)
        M_IDLE: begin
          if (start) begin
            mc_r  <= mag_a;
            lo_r  <= mag_b;
            hi_r  <= '0;
            neg_r <= a[VB-1] ^ b[VB-1];
            cnt_r <= '0;
            st_r  <= M_RUN;
          end
        end
        M_RUN: begin
          hi_r  <= psum[VB:1];
          lo_r  <= {psum[0], lo_r[VB-1:1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(VB - 1)) begin
            st_r <= M_FIN;
          end
        end
        M_FIN: begin
          if (rnd > P_HI) begin
            p_r   <= P_HI[VB-1:0];
            err_r <= 1'b1;
          end else if (rnd < P_LO) begin
            p_r   <= P_LO[VB-1:0];
            err_r <= 1'b1;
          end else begin
            p_r   <= rnd[VB-1:0];
            err_r <= 1'b0;
          end
          st_r <= M_IDLE;
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end

  assign busy = (st_r != M_IDLE);
  assign done = done_r;
  assign p    = p_r;
  assign err  = err_r;

endmodule

@@ design/hcm_div.sv @@
// Restoring divider: -(num / den) in fixed point, truncated toward zero and
// saturated to RB bits. Depends on hcm_pkg for parameter defaults.
module hcm_div #(
  parameter int VB = hcm_pkg::VALUE_BITS_DEF,
  parameter int FB = hcm_pkg::FRAC_BITS_DEF,
  parameter int RB = hcm_pkg::FIELD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [VB-1:0] num,
  input  logic signed [VB-1:0] den,
  output logic                 done,
  output logic signed [VB-1:0] q,
  output logic                 err
);

  localparam int W  = VB + FB;
  localparam int CW = $clog2(W + 1);
  localparam logic [W-1:0] LIM_POS = W'(1) << (RB - 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t              st_r;
  logic [CW-1:0]        cnt_r;
  logic [VB-1:0]        rem_r;
  logic [W-1:0]         dq_r;
  logic [VB-1:0]        un_r;
  logic                 neg_r;
  logic                 done_r;
  logic signed [VB-1:0] q_r;
  logic                 err_r;

  logic [VB-1:0] mag_n;
  logic [VB-1:0] mag_d;
  logic [VB:0]   rs;
  logic [VB:0]   diff;
  logic          ge;
  logic [W-1:0]  lim;
  logic [VB-1:0] ql;

  assign mag_n = num[VB-1] ? (~num + 1'b1) : num;
  assign mag_d = den[VB-1] ? (~den + 1'b1) : den;
  assign rs    = {rem_r, dq_r[W-1]};
  assign diff  = rs - {1'b0, un_r};
  assign ge    = (rs >= {1'b0, un_r});
  assign lim   = neg_r ? LIM_POS : (LIM_POS - 1'b1);
  assign ql    = (dq_r > lim) ? lim[VB-1:0] : dq_r[VB-1:0];

  // One quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == D_FIN);
      unique case (st_r)
        D_IDLE: begin
          if (start) begin
            rem_r <= '0;
            dq_r  <= {mag_n, {FB{1'b0}}};
            un_r  <= mag_d;
            neg_r <= (num[VB-1] == den[VB-1]);
            cnt_r <= '0;
            st_r  <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= ge ? diff[VB-1:0] : rs[VB-1:0];
          dq_r  <= {dq_r[W-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(W - 1)) begin
            st_r <= D_FIN;
          end
        end
        D_FIN: begin
          err_r <= (dq_r > lim);
          q_r   <= neg_r ? (~ql + 1'b1) : ql;
          st_r  <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign q    = q_r;
  assign err  = err_r;

endmodule

@@ design/hcm_dp.sv @@
// Datapath: operand memory, accumulator, saturating adder and the shared
// multiply and divide units. Depends on hcm_pkg, hcm_mul and hcm_div.
module hcm_dp #(
  parameter int MAX_DIM    = hcm_pkg::MAX_DIM_DEF,
  parameter int VALUE_BITS = hcm_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = hcm_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hcm_pkg::hcm_cmd_t                     cmd,
  output hcm_pkg::hcm_sts_t                     sts,
  input  logic [hcm_pkg::SLOT_BITS-1:0]         in_slot,
  input  logic signed [hcm_pkg::FIELD_BITS-1:0] in_value,
  output logic [hcm_pkg::IDX_BITS-1:0]          out_idx,
  output logic signed [hcm_pkg::FIELD_BITS-1:0] out_value,
  output logic                                  out_err,
  output logic                                  out_last
);

  localparam int VB     = VALUE_BITS;
  localparam int FW     = hcm_pkg::FIELD_BITS;
  localparam int RB     = (VB < FW) ? VB : FW;
  localparam int NSLOTS = hcm_pkg::nslots(MAX_DIM);
  localparam int AW     = $clog2(NSLOTS);
  localparam int SW     = VB + 2;
  localparam int XW     = ((VB > FW) ? VB : FW) + 1;
  localparam logic signed [SW-1:0] S_HI = (SW'(1) <<< (VB - 1)) - SW'(1);
  localparam logic signed [SW-1:0] S_LO = -S_HI - SW'(1);
  localparam logic signed [XW-1:0] X_HI = (XW'(1) <<< (VB - 1)) - XW'(1);
  localparam logic signed [XW-1:0] X_LO = -X_HI - XW'(1);

  logic signed [VB-1:0] mem [NSLOTS];
  logic signed [VB-1:0] mem_q_r;
  logic signed [VB-1:0] n_r;
  logic signed [VB-1:0] opa_r;
  logic signed [VB-1:0] acc_r;
  logic                 err_r;
  logic [hcm_pkg::IDX_BITS-1:0] idx_r;
  logic signed [FW-1:0] val_r;
  logic                 oerr_r;
  logic                 last_r;

  logic signed [XW-1:0] xin;
  logic signed [VB-1:0] wr_val;
  logic signed [VB-1:0] mul_a;
  logic                 mul_busy;
  logic                 mul_done;
  logic signed [VB-1:0] mul_p;
  logic                 mul_err;
  logic                 div_done;
  logic signed [VB-1:0] div_q;
  logic                 div_err;
  logic signed [XW-1:0] qx;
  logic [VB:0]          vsat;
  logic [VB:0]          rsat;

  // Saturate a widened sum to VB bits; top bit of the result is the flag
  function automatic logic [VB:0] sat(input logic signed [SW-1:0] x);
    logic [VB:0] r;
    if (x > S_HI) begin
      r = {1'b1, S_HI[VB-1:0]};
    end else if (x < S_LO) begin
      r = {1'b1, S_LO[VB-1:0]};
    end else begin
      r = {1'b0, x[VB-1:0]};
    end
    return r;
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic signed [VB-1:0] v);
    return {{2{v[VB-1]}}, v};
  endfunction

  // Clamp the loaded word into the value width
  always_comb begin
    xin = {{(XW-FW){in_value[FW-1]}}, in_value};
    if (xin > X_HI) begin
      wr_val = X_HI[VB-1:0];
    end else if (xin < X_LO) begin
      wr_val = X_LO[VB-1:0];
    end else begin
      wr_val = xin[VB-1:0];
    end
  end

  // Operand memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en && (int'(in_slot) < NSLOTS)) begin
      mem[in_slot[AW-1:0]] <= wr_val;
    end
    mem_q_r <= mem[cmd.rd_slot[AW-1:0]];
  end

  assign mul_a = cmd.mul_sel_prod ? mul_p : opa_r;

  hcm_mul #(.VB(VB), .FB(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mem_q_r),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p),
    .err   (mul_err)
  );

  hcm_div #(.VB(VB), .FB(FRAC_BITS), .RB(RB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (acc_r),
    .den   (n_r),
    .done  (div_done),
    .q     (div_q),
    .err   (div_err)
  );

  // Term value (optionally doubled) and accumulator update
  always_comb begin
    if (cmd.comb_dbl) begin
      vsat = sat(ext(mul_p) + ext(mul_p));
    end else begin
      vsat = {1'b0, mul_p};
    end
    if (cmd.comb_sub) begin
      rsat = sat(ext(acc_r) - ext(vsat[VB-1:0]));
    end else begin
      rsat = sat(ext(acc_r) + ext(vsat[VB-1:0]));
    end
  end

  assign qx = {{(XW-VB){div_q[VB-1]}}, div_q};

  // Hold lapse, operand latch, accumulator and the error flag
  always_ff @(posedge clk) begin
    if (cmd.ld_n) begin
      n_r <= mem_q_r;
    end
    if (cmd.ld_opa) begin
      opa_r <= mem_q_r;
    end
    if (!rst_n) begin
      err_r <= 1'b0;
    end else if (cmd.acc_clr) begin
      err_r <= 1'b0;
    end else if ((mul_done && mul_err) ||
                 (cmd.comb && !cmd.comb_load && (vsat[VB] || rsat[VB]))) begin
      err_r <= 1'b1;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.comb) begin
      acc_r <= cmd.comb_load ? opa_r : rsat[VB-1:0];
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      idx_r  <= cmd.out_idx;
      last_r <= cmd.out_last;
      if (cmd.res_zero) begin
        val_r  <= '0;
        oerr_r <= 1'b1;
      end else begin
        val_r  <= qx[FW-1:0];
        oerr_r <= err_r | div_err;
      end
    end
  end

  assign sts.n_zero   = (n_r == '0);
  assign sts.mul_busy = mul_busy;
  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;

  assign out_idx   = idx_r;
  assign out_value = val_r;
  assign out_err   = oerr_r;
  assign out_last  = last_r;

endmodule

@@ design/hcm_ctrl.sv @@
// Controller: sequences operand loads, product terms, the divide and the
// output handshake per component. Depends on hcm_pkg.
module hcm_ctrl #(
  parameter int MAX_DIM = hcm_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [hcm_pkg::DIM_BITS-1:0]  dim_cfg,
  input  logic                          in_valid,
  input  logic                          in_last,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hcm_pkg::hcm_cmd_t             cmd,
  input  hcm_pkg::hcm_sts_t             sts
);

  localparam int DW = $clog2(MAX_DIM + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RDN, S_LDN, S_CSTART, S_RD1, S_RD2, S_MUL1, S_MW1,
    S_MUL2, S_MW2, S_COMB, S_DIV, S_DW, S_OUT
  } state_t;

  typedef enum logic [1:0] {PH_HEAD, PH_SUM, PH_PHI} phase_t;

  state_t        state_r;
  phase_t        ph_r;
  logic [DW-1:0] a_r;
  logic [DW-1:0] b_r;
  logic [DW-1:0] m_r;
  logic [DW-1:0] i_r;
  logic          sub_r;
  logic          out_valid_r;

  logic [DW-1:0] d;
  logic [DW-1:0] dm1;
  logic          k00;
  logic          k0b;
  logic          last_c;
  logic [hcm_pkg::SLOT_BITS-1:0] slot1;
  logic [hcm_pkg::SLOT_BITS-1:0] slot2;
  logic [hcm_pkg::SLOT_BITS-1:0] slot3;
  logic [1:0]    nops;
  logic          t_dbl;
  logic          t_sub;
  logic          t_load;

  // Dimension in use: zero acts as one, large values as the maximum
  always_comb begin
    if (dim_cfg == '0) begin
      d = DW'(1);
    end else if (int'(dim_cfg) > MAX_DIM) begin
      d = DW'(MAX_DIM);
    end else begin
      d = DW'(dim_cfg);
    end
  end

  assign dm1    = d - 1'b1;
  assign k00    = (a_r == '0) && (b_r == '0);
  assign k0b    = (a_r == '0) && (b_r != '0);
  assign last_c = (a_r == d) && (b_r == d);

  // Operand slots and combine mode of the current term
  always_comb begin
    slot1  = hcm_pkg::SLOT_LAPSE;
    slot2  = hcm_pkg::SLOT_LAPSE;
    slot3  = hcm_pkg::SLOT_LAPSE;
    nops   = 2'd2;
    t_dbl  = 1'b0;
    t_sub  = 1'b0;
    t_load = 1'b0;
    unique case (ph_r)
      PH_HEAD: begin
        if (k00) begin
          slot1 = hcm_pkg::SLOT_LAPSE;
          slot2 = hcm_pkg::SLOT_DT_LAPSE;
          t_dbl = 1'b1;
          t_sub = 1'b1;
        end else begin
          slot1  = hcm_pkg::slot_dtg(int'(a_r) - 1, int'(b_r) - 1, MAX_DIM);
          nops   = 2'd1;
          t_load = 1'b1;
        end
      end
      PH_SUM: begin
        if (k00) begin
          nops  = 2'd3;
          slot2 = hcm_pkg::slot_shift(int'(m_r), MAX_DIM);
          if (sub_r) begin
            slot1 = hcm_pkg::slot_g(int'(m_r), int'(i_r), MAX_DIM);
            slot3 = hcm_pkg::slot_dtshift(int'(i_r), MAX_DIM);
            t_dbl = 1'b1;
          end else begin
            slot1 = hcm_pkg::slot_dtg(int'(m_r), int'(i_r), MAX_DIM);
            slot3 = hcm_pkg::slot_shift(int'(i_r), MAX_DIM);
          end
        end else begin
          if (sub_r) begin
            slot1 = hcm_pkg::slot_g(int'(m_r), int'(b_r) - 1, MAX_DIM);
            slot2 = hcm_pkg::slot_dtshift(int'(m_r), MAX_DIM);
          end else begin
            slot1 = hcm_pkg::slot_dtg(int'(m_r), int'(b_r) - 1, MAX_DIM);
            slot2 = hcm_pkg::slot_shift(int'(m_r), MAX_DIM);
          end
        end
      end
      PH_PHI: begin
        slot1 = hcm_pkg::slot_shift(int'(i_r), MAX_DIM);
        slot2 = hcm_pkg::slot_phi(int'(i_r),
                  hcm_pkg::sym_idx(int'(a_r), int'(b_r), MAX_DIM + 1), MAX_DIM);
        t_sub = 1'b1;
      end
      default: begin
        nops = 2'd2;
      end
    endcase
  end

  // State, counters and the output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_HEAD;
      a_r         <= '0;
      b_r         <= '0;
      m_r         <= '0;
      i_r         <= '0;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_last) begin
            state_r <= S_RDN;
          end
        end
        S_RDN: state_r <= S_LDN;
        S_LDN: begin
          a_r     <= '0;
          b_r     <= '0;
          state_r <= S_CSTART;
        end
        S_CSTART: begin
          m_r   <= '0;
          i_r   <= '0;
          sub_r <= 1'b0;
          if (sts.n_zero) begin
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            ph_r    <= k0b ? PH_SUM : PH_HEAD;
            state_r <= S_RD1;
          end
        end
        S_RD1: state_r <= S_RD2;
        S_RD2: state_r <= (nops == 2'd1) ? S_COMB : S_MUL1;
        S_MUL1: state_r <= S_MW1;
        S_MW1: begin
          if (sts.mul_done) begin
            state_r <= (nops == 2'd3) ? S_MUL2 : S_COMB;
          end
        end
        S_MUL2: state_r <= S_MW2;
        S_MW2: begin
          if (sts.mul_done) begin
            state_r <= S_COMB;
          end
        end
        S_COMB: begin
          unique case (ph_r)
            PH_HEAD: begin
              state_r <= S_RD1;
              ph_r    <= k00 ? PH_SUM : PH_PHI;
              m_r     <= '0;
              i_r     <= '0;
              sub_r   <= 1'b0;
            end
            PH_SUM: begin
              state_r <= S_RD1;
              if (!sub_r) begin
                sub_r <= 1'b1;
              end else begin
                sub_r <= 1'b0;
                if (k00) begin
                  if (i_r == dm1) begin
                    i_r <= '0;
                    if (m_r == dm1) begin
                      ph_r <= PH_PHI;
                    end else begin
                      m_r <= m_r + 1'b1;
                    end
                  end else begin
                    i_r <= i_r + 1'b1;
                  end
                end else begin
                  if (m_r == dm1) begin
                    ph_r <= PH_PHI;
                    i_r  <= '0;
                  end else begin
                    m_r <= m_r + 1'b1;
                  end
                end
              end
            end
            PH_PHI: begin
              if (i_r == dm1) begin
                state_r <= S_DIV;
              end else begin
                state_r <= S_RD1;
                i_r     <= i_r + 1'b1;
              end
            end
            default: begin
              state_r <= S_RD1;
              ph_r    <= PH_HEAD;
            end
          endcase
        end
        S_DIV: state_r <= S_DW;
        S_DW: begin
          if (sts.div_done) begin
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (last_c) begin
              state_r <= S_IDLE;
            end else begin
              if (b_r == d) begin
                a_r <= a_r + 1'b1;
                b_r <= a_r + 1'b1;
              end else begin
                b_r <= b_r + 1'b1;
              end
              state_r <= S_CSTART;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.wr_en    = (state_r == S_IDLE) && in_valid;
    cmd.out_idx  = hcm_pkg::comp_idx(int'(a_r), int'(b_r), MAX_DIM);
    cmd.out_last = last_c;
    unique case (state_r)
      S_RDN:    cmd.rd_slot = hcm_pkg::SLOT_LAPSE;
      S_LDN:    cmd.ld_n = 1'b1;
      S_CSTART: begin
        cmd.acc_clr  = 1'b1;
        cmd.res_zero = 1'b1;
        cmd.out_load = sts.n_zero;
      end
      S_RD1:    cmd.rd_slot = slot1;
      S_RD2: begin
        cmd.rd_slot = slot2;
        cmd.ld_opa  = 1'b1;
      end
      S_MUL1: begin
        cmd.rd_slot   = slot3;
        cmd.mul_start = 1'b1;
      end
      S_MW1, S_MW2: cmd.rd_slot = slot3;
      S_MUL2: begin
        cmd.rd_slot      = slot3;
        cmd.mul_start    = 1'b1;
        cmd.mul_sel_prod = 1'b1;
      end
      S_COMB: begin
        cmd.comb      = 1'b1;
        cmd.comb_load = t_load;
        cmd.comb_dbl  = t_dbl;
        cmd.comb_sub  = t_sub;
      end
      S_DIV:    cmd.div_start = 1'b1;
      S_DW:     cmd.out_load = sts.div_done;
      default:  cmd.rd_slot = hcm_pkg::SLOT_LAPSE;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Never take an operand while a result word is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid_r))
    else $error("operand accepted while result pending");

  // Start the multiplier only when it is free
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !sts.mul_busy)
    else $error("multiplier started while busy");

  // Products complete only while a multiply is awaited
  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mul_done |-> (state_r == S_MW1 || state_r == S_MW2))
    else $error("unexpected product");

  // Quotients complete only while the divide is awaited
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DW))
    else $error("unexpected quotient");

endmodule

@@ design/harmonic_conjugate_momentum.sv @@
// Top level: channels, configuration register, controller and datapath.
// Depends on hcm_pkg, hcm_if, hcm_ctrl and hcm_dp.
//
//   channel  | direction | handshake          | payload
//   in_ch    | sink      | valid/ready        | operand_slot, operand_value, last_operand
//   out_ch   | source    | valid/ready        | component_index/value, error_flag, last
//   cfg_*    | slave     | APB, pready high   | spatial_dim at byte address 0
//
// Each operand word is accepted while idle; the last word starts the point.
// Per component: two-factor and three-factor product terms on the shared
// multiplier, then the divide.
// Reset is synchronous, active low; the operand memory is not cleared.
// A stalled result holds the block; operands are refused until all results go.
module harmonic_conjugate_momentum #(
  parameter int MAX_DIM    = hcm_pkg::MAX_DIM_DEF,
  parameter int VALUE_BITS = hcm_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = hcm_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hcm_in_if.sink      in_ch,
  hcm_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [hcm_pkg::DIM_BITS-1:0] spatial_dim_r;
  hcm_pkg::hcm_cmd_t            cmd;
  hcm_pkg::hcm_sts_t            sts;
  logic                         in_ready;
  logic                         out_valid;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spatial_dim_r <= hcm_pkg::DIM_BITS'(3);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      spatial_dim_r <= cfg_pwdata[hcm_pkg::DIM_BITS-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {30'd0, spatial_dim_r};

  hcm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .dim_cfg   (spatial_dim_r),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_operand),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  hcm_dp #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_slot   (in_ch.operand_slot),
    .in_value  (in_ch.operand_value),
    .out_idx   (out_ch.component_index),
    .out_value (out_ch.component_value),
    .out_err   (out_ch.error_flag),
    .out_last  (out_ch.last_component)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
